// File: design/clfr_pkg.sv
// Shared types, constants and functions of the combined lagged Fibonacci generator.
`timescale 1ns / 1ps
`default_nettype none
package clfr_pkg;

    localparam int WORD_W  = 32;
    localparam int SEL_W   = 2;
    localparam int INDEX_W = 11;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_GEN  = 1'b1;

    localparam logic [SEL_W-1:0] SEL_A = 2'd0;
    localparam logic [SEL_W-1:0] SEL_B = 2'd1;
    localparam logic [SEL_W-1:0] SEL_C = 2'd2;

    localparam int ROT_B_LSB = 8;
    localparam int ROT_C_LSB = 16;
    localparam int ROT_M_LSB = 24;
    localparam int ROT_W     = 5;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic read;
        logic step;
        logic load;
    } t_lag_cmd;

    function automatic t_word rotr(input t_word x, input logic [ROT_W-1:0] s);
        logic [2*WORD_W-1:0] d;
        d = {x, x} >> s;
        return d[WORD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: design/combined_lagged_fibonacci_rng.sv
// Top level of the combined lagged Fibonacci random word generator.
//
// A load item writes one seed word into generator A, B or C, resetting that generator's
// pointers and dropping any held word. A generate item that finds a held word returns it
// through the output register. A generate item that must step the generators passes the
// memory read of rear and front words, the add with write-back, and the rotate-and-merge
// into the output register; it returns one word and holds the other, so a stream of
// generate items alternates between steps and held words. The step is set by the registered
// read of the word memories and the write-back that follows it. No new item is taken during
// a step, nor while a result waits in the output register. Generator words have no reset,
// and every word that a step reads must have been loaded before; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module combined_lagged_fibonacci_rng #(
    parameter int LONG_LAG_A  = 367,
    parameter int SHORT_LAG_A = 171,
    parameter int LONG_LAG_B  = 887,
    parameter int SHORT_LAG_B = 336,
    parameter int LONG_LAG_C  = 1489,
    parameter int SHORT_LAG_C = 252
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_operation,
    input  wire logic [clfr_pkg::SEL_W-1:0]   i_generator_select,
    input  wire logic [clfr_pkg::INDEX_W-1:0] i_word_index,
    input  wire logic [clfr_pkg::WORD_W-1:0]  i_seed_word,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [clfr_pkg::WORD_W-1:0]       o_random_word
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_MIX  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    clfr_pkg::t_word    r_out_word, n_out_word;
    logic               r_held_valid, n_held_valid;
    clfr_pkg::t_word    r_held_word, n_held_word;
    clfr_pkg::t_word    r_sum_a, r_sum_b, r_sum_c;

    logic               accept;
    logic               acc_load;
    logic               acc_gen_held;
    logic               acc_gen_step;
    logic               sel_ok;
    clfr_pkg::t_lag_cmd cmd_a, cmd_b, cmd_c;
    clfr_pkg::t_word    sum_a, sum_b, sum_c;
    clfr_pkg::t_word    mix_first, mix_second;

    assign o_ready       = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign o_valid       = r_out_valid;
    assign o_random_word = r_out_word;

    assign accept       = i_valid && o_ready;
    assign acc_load     = accept && (i_operation == clfr_pkg::OP_LOAD);
    assign acc_gen_held = accept && (i_operation == clfr_pkg::OP_GEN) && r_held_valid;
    assign acc_gen_step = accept && (i_operation == clfr_pkg::OP_GEN) && !r_held_valid;
    assign sel_ok       = (i_generator_select == clfr_pkg::SEL_A)
                       || (i_generator_select == clfr_pkg::SEL_B)
                       || (i_generator_select == clfr_pkg::SEL_C);

    always_comb begin
        cmd_a.read = acc_gen_step;
        cmd_a.step = (r_state == S_READ);
        cmd_a.load = acc_load && (i_generator_select == clfr_pkg::SEL_A);
        cmd_b.read = acc_gen_step;
        cmd_b.step = (r_state == S_READ);
        cmd_b.load = acc_load && (i_generator_select == clfr_pkg::SEL_B);
        cmd_c.read = acc_gen_step;
        cmd_c.step = (r_state == S_READ);
        cmd_c.load = acc_load && (i_generator_select == clfr_pkg::SEL_C);
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_out_word   = r_out_word;
        n_held_valid = r_held_valid;
        n_held_word  = r_held_word;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (acc_load && sel_ok) begin
                    n_held_valid = 1'b0;
                end
                if (acc_gen_held) begin
                    n_held_valid = 1'b0;
                    n_out_valid  = 1'b1;
                    n_out_word   = r_held_word;
                end
                if (acc_gen_step) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_MIX;
            end
            S_MIX: begin
                n_state      = S_IDLE;
                n_out_valid  = 1'b1;
                n_out_word   = mix_second;
                n_held_valid = 1'b1;
                n_held_word  = mix_first;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_word  <= '0;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_held_valid <= n_held_valid;
            r_held_word  <= n_held_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        if (r_state == S_READ) begin
            r_sum_a <= sum_a;
            r_sum_b <= sum_b;
            r_sum_c <= sum_c;
        end
    end

    clfr_lag #(
        .LONG_LAG  (LONG_LAG_A),
        .SHORT_LAG (SHORT_LAG_A)
    ) u_lag_a (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_a),
        .i_load_index (i_word_index),
        .i_seed_word  (i_seed_word),
        .o_sum        (sum_a)
    );

    clfr_lag #(
        .LONG_LAG  (LONG_LAG_B),
        .SHORT_LAG (SHORT_LAG_B)
    ) u_lag_b (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_b),
        .i_load_index (i_word_index),
        .i_seed_word  (i_seed_word),
        .o_sum        (sum_b)
    );

    clfr_lag #(
        .LONG_LAG  (LONG_LAG_C),
        .SHORT_LAG (SHORT_LAG_C)
    ) u_lag_c (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_c),
        .i_load_index (i_word_index),
        .i_seed_word  (i_seed_word),
        .o_sum        (sum_c)
    );

    clfr_mix u_mix (
        .i_sum_a  (r_sum_a),
        .i_sum_b  (r_sum_b),
        .i_sum_c  (r_sum_c),
        .o_first  (mix_first),
        .o_second (mix_second)
    );

endmodule
`default_nettype wire

// File: design/clfr_ram.sv
// Generic single-write, dual-read memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module clfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
`default_nettype wire

// File: design/clfr_lag.sv
// One lagged Fibonacci generator: word memory, rear and front pointers, adder.
`timescale 1ns / 1ps
`default_nettype none
module clfr_lag #(
    parameter int LONG_LAG  = 367,
    parameter int SHORT_LAG = 171
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire clfr_pkg::t_lag_cmd           i_cmd,
    input  wire logic [clfr_pkg::INDEX_W-1:0] i_load_index,
    input  wire clfr_pkg::t_word              i_seed_word,
    output clfr_pkg::t_word                   o_sum
);

    localparam int AW     = $clog2(LONG_LAG);
    localparam int FRONT0 = SHORT_LAG % LONG_LAG;

    logic [AW-1:0]   r_rear, n_rear;
    logic [AW-1:0]   r_front, n_front;
    logic            load_wr;
    logic            we;
    logic [AW-1:0]   waddr;
    clfr_pkg::t_word wdata;
    clfr_pkg::t_word rd_rear;
    clfr_pkg::t_word rd_front;

    assign load_wr = i_cmd.load && (32'(i_load_index) < 32'(LONG_LAG));
    assign o_sum   = rd_front + rd_rear;
    assign we      = load_wr || i_cmd.step;
    assign waddr   = load_wr ? AW'(i_load_index) : r_front;
    assign wdata   = load_wr ? i_seed_word : o_sum;

    always_comb begin
        n_rear  = r_rear;
        n_front = r_front;
        if (i_cmd.load) begin
            n_rear  = '0;
            n_front = AW'(FRONT0);
        end else if (i_cmd.step) begin
            n_rear  = (r_rear == AW'(LONG_LAG - 1)) ? '0 : r_rear + 1'b1;
            n_front = (r_front == AW'(LONG_LAG - 1)) ? '0 : r_front + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rear  <= '0;
            r_front <= AW'(FRONT0);
        end else begin
            r_rear  <= n_rear;
            r_front <= n_front;
        end
    end

    clfr_ram #(
        .WIDTH (clfr_pkg::WORD_W),
        .DEPTH (LONG_LAG)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (i_cmd.read),
        .i_raddr_a (r_rear),
        .i_raddr_b (r_front),
        .o_rdata_a (rd_rear),
        .o_rdata_b (rd_front)
    );

endmodule
`default_nettype wire

// File: design/clfr_mix.sv
// Rotation and mask merge of the three generator sums into two output words.
`timescale 1ns / 1ps
`default_nettype none
module clfr_mix (
    input  wire clfr_pkg::t_word i_sum_a,
    input  wire clfr_pkg::t_word i_sum_b,
    input  wire clfr_pkg::t_word i_sum_c,
    output clfr_pkg::t_word      o_first,
    output clfr_pkg::t_word      o_second
);

    clfr_pkg::t_word rot_b;
    clfr_pkg::t_word rot_c;
    clfr_pkg::t_word mask;

    assign rot_b = clfr_pkg::rotr(i_sum_b,
        i_sum_a[clfr_pkg::ROT_B_LSB +: clfr_pkg::ROT_W]);
    assign rot_c = clfr_pkg::rotr(i_sum_c,
        i_sum_a[clfr_pkg::ROT_C_LSB +: clfr_pkg::ROT_W]);
    assign mask  = clfr_pkg::rotr(i_sum_a,
        i_sum_a[clfr_pkg::ROT_M_LSB +: clfr_pkg::ROT_W]);

    assign o_first  = (rot_b & mask) | (rot_c & ~mask);
    assign o_second = (rot_c & mask) | (rot_b & ~mask);

endmodule
`default_nettype wire

// File: design/clfr_checker.sv
// Port-level checker of the combined lagged Fibonacci generator and its bind.
`timescale 1ns / 1ps
`default_nettype none
module clfr_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_valid,
    input wire logic                         o_ready,
    input wire logic                         i_operation,
    input wire logic                         o_valid,
    input wire logic                         i_ready,
    input wire logic [clfr_pkg::WORD_W-1:0]  o_random_word
);

    logic in_xfer;
    logic out_free;

    assign in_xfer  = i_valid && o_ready;
    assign out_free = !o_valid || i_ready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("Output valid dropped before its transfer.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_random_word))
        else $error("Output word changed while stalled.");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_operation == clfr_pkg::OP_LOAD) && out_free |=> !o_valid)
        else $error("A load transfer produced an output word.");

    a_gen_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && (i_operation == clfr_pkg::OP_GEN) && out_free |=> o_valid || !o_ready)
        else $error("A generate transfer neither returned a word nor started a step.");

endmodule

bind combined_lagged_fibonacci_rng clfr_checker u_clfr_checker (.*);
`default_nettype wire
